### design/ptz_command_frame_encoder_assert.svh
// assertion macros for the ptz command frame encoder checks
// both expect clk and rst_n in the scope where they are used
`ifndef PTZ_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define PTZ_COMMAND_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define PCFE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptz frame check failed");

// next-cycle implication
`define PCFE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptz frame check failed");

`endif

### design/pcfe_pkg.sv
`timescale 1ns / 1ps

package pcfe_pkg;

    // input item layout in tdata, lowest bit first
    localparam int MODE_W      = 4;
    localparam int ANGLE_W     = 17;
    localparam int SPEED_W     = 8;
    localparam int INTERVAL_W  = 16;
    localparam int MODE_LSB     = 0;
    localparam int ANGLE_LSB    = MODE_LSB + MODE_W;
    localparam int SPEED_LSB    = ANGLE_LSB + ANGLE_W;
    localparam int INTERVAL_LSB = SPEED_LSB + SPEED_W;
    localparam int IN_BITS      = INTERVAL_LSB + INTERVAL_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    localparam int BYTE_W    = 8;
    localparam int FRAME_LEN = 7;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h01;

    localparam logic [BYTE_W-1:0] CMD1_REPORT   = 8'hE1;
    localparam logic [BYTE_W-1:0] CMD1_REACH    = 8'hC5;
    localparam logic [BYTE_W-1:0] CMD2_ON       = 8'h01;
    localparam logic [BYTE_W-1:0] CMD2_OFF      = 8'h02;
    localparam logic [BYTE_W-1:0] CMD2_REACH_ON = 8'h01;
    localparam logic [BYTE_W-1:0] CMD2_REACH_OFF = 8'h00;
    localparam logic [BYTE_W-1:0] CMD2_PAN_TO   = 8'h4B;
    localparam logic [BYTE_W-1:0] CMD2_TILT_TO  = 8'h4D;
    localparam logic [BYTE_W-1:0] CMD2_Q_PAN    = 8'h51;
    localparam logic [BYTE_W-1:0] CMD2_Q_TILT   = 8'h53;
    localparam logic [BYTE_W-1:0] CMD2_UP       = 8'h08;
    localparam logic [BYTE_W-1:0] CMD2_DOWN     = 8'h10;
    localparam logic [BYTE_W-1:0] CMD2_LEFT     = 8'h04;
    localparam logic [BYTE_W-1:0] CMD2_RIGHT    = 8'h02;

    // one bit of headroom over the 17-bit angle
    localparam logic signed [ANGLE_W:0] FULL_TURN = 18'sd36000;
    localparam logic signed [ANGLE_W:0] HALF_TURN = 18'sd18000;

    typedef enum logic [MODE_W-1:0] {
        MODE_REPORT_ON  = 4'd0,
        MODE_REPORT_OFF = 4'd1,
        MODE_REACH_ON   = 4'd2,
        MODE_REACH_OFF  = 4'd3,
        MODE_PAN_TO     = 4'd4,
        MODE_TILT_TO    = 4'd5,
        MODE_STOP       = 4'd6,
        MODE_QUERY_PAN  = 4'd7,
        MODE_QUERY_TILT = 4'd8,
        MODE_UP         = 4'd9,
        MODE_DOWN       = 4'd10,
        MODE_LEFT       = 4'd11,
        MODE_RIGHT      = 4'd12
    } mode_t;

    // negative angles wrap up by a turn, then one conditional subtract does the remainder
    function automatic logic [15:0] pan_word(input logic [ANGLE_W-1:0] angle);
        logic signed [ANGLE_W:0] a;
        logic signed [ANGLE_W:0] r;
        a = {angle[ANGLE_W-1], angle};
        if (a < 0)
            a = a + FULL_TURN;
        r = (a >= FULL_TURN) ? a - FULL_TURN : a;
        return r[15:0];
    endfunction

    // angles above a half turn wrap down by a turn, then one conditional add fixes the low side
    function automatic logic [15:0] tilt_word(input logic [ANGLE_W-1:0] angle);
        logic signed [ANGLE_W:0] a;
        logic signed [ANGLE_W:0] r;
        a = {angle[ANGLE_W-1], angle};
        if (a > HALF_TURN)
            a = a - FULL_TURN;
        r = (a <= -FULL_TURN) ? a + FULL_TURN : a;
        return r[15:0];
    endfunction

endpackage

### design/ptz_command_frame_encoder.sv
`timescale 1ns / 1ps

// an accepted command passes the input register, then loads the frame register when idle
// the seven-byte output serialiser sends one frame at a time and stalls on tready
// one further command waits in the input register while a frame drains
// reset: async active low, clears valid flags and sets the device address to 1
module ptz_command_frame_encoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // mode[3:0], angle_hundredths[20:4], speed[28:21], report_interval[44:29], zero pad
    input  logic [pcfe_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // frame_byte[7:0]
    output logic [pcfe_pkg::BYTE_W-1:0]        m_axis_tdata,
    // last_byte
    output logic                               m_axis_tlast,
    input  logic                               cfg_wr_en,
    input  logic [pcfe_pkg::BYTE_W-1:0]        cfg_wr_data
);
    import pcfe_pkg::*;

    logic                  in_valid_reg;
    mode_t                 mode_reg;
    logic [ANGLE_W-1:0]    angle_reg;
    logic [SPEED_W-1:0]    speed_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [BYTE_W-1:0]     device_address_reg;

    logic                  busy_reg;
    logic [IDX_W-1:0]      byte_idx_reg;
    logic [BYTE_W-1:0]     frame_reg [FRAME_LEN];

    logic                  in_take;
    logic                  out_take;
    logic                  frame_done;
    logic                  load;
    logic                  mode_ok;
    logic [15:0]           pan_w;
    logic [15:0]           tilt_w;
    logic [BYTE_W-1:0]     cmd1;
    logic [BYTE_W-1:0]     cmd2;
    logic [BYTE_W-1:0]     data1;
    logic [BYTE_W-1:0]     data2;
    logic [BYTE_W-1:0]     checksum;

    assign out_take   = m_axis_tvalid && m_axis_tready;
    assign frame_done = out_take && (byte_idx_reg == LAST_IDX);
    // undefined modes also pass through here and are simply dropped
    assign load       = in_valid_reg && (!busy_reg || frame_done);
    assign s_axis_tready = !in_valid_reg || load;
    assign in_take    = s_axis_tvalid && s_axis_tready;

    assign pan_w  = pan_word(angle_reg);
    assign tilt_w = tilt_word(angle_reg);

    always_comb
    begin
        mode_ok = 1'b1;
        cmd1    = '0;
        cmd2    = '0;
        data1   = '0;
        data2   = '0;
        case (mode_reg)
            MODE_REPORT_ON:
            begin
                cmd1  = CMD1_REPORT;
                cmd2  = CMD2_ON;
                data1 = interval_reg[15:8];
                data2 = interval_reg[7:0];
            end
            MODE_REPORT_OFF:
            begin
                cmd1 = CMD1_REPORT;
                cmd2 = CMD2_OFF;
            end
            MODE_REACH_ON:
            begin
                cmd1 = CMD1_REACH;
                cmd2 = CMD2_REACH_ON;
            end
            MODE_REACH_OFF:
            begin
                cmd1 = CMD1_REACH;
                cmd2 = CMD2_REACH_OFF;
            end
            MODE_PAN_TO:
            begin
                cmd2  = CMD2_PAN_TO;
                data1 = pan_w[15:8];
                data2 = pan_w[7:0];
            end
            MODE_TILT_TO:
            begin
                cmd2  = CMD2_TILT_TO;
                data1 = tilt_w[15:8];
                data2 = tilt_w[7:0];
            end
            MODE_STOP:
            begin
                cmd2 = '0;
            end
            MODE_QUERY_PAN:
            begin
                cmd2 = CMD2_Q_PAN;
            end
            MODE_QUERY_TILT:
            begin
                cmd2 = CMD2_Q_TILT;
            end
            MODE_UP:
            begin
                cmd2  = CMD2_UP;
                data2 = speed_reg;
            end
            MODE_DOWN:
            begin
                cmd2  = CMD2_DOWN;
                data2 = speed_reg;
            end
            MODE_LEFT:
            begin
                cmd2  = CMD2_LEFT;
                data1 = speed_reg;
            end
            MODE_RIGHT:
            begin
                cmd2  = CMD2_RIGHT;
                data1 = speed_reg;
            end
            default:
            begin
                mode_ok = 1'b0;
            end
        endcase
        checksum = device_address_reg + cmd1 + cmd2 + data1 + data2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            busy_reg           <= 1'b0;
            byte_idx_reg       <= '0;
            device_address_reg <= ADDRESS_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                device_address_reg <= cfg_wr_data;

            if (in_take)
                in_valid_reg <= 1'b1;
            else if (load)
                in_valid_reg <= 1'b0;

            if (load && mode_ok)
            begin
                busy_reg     <= 1'b1;
                byte_idx_reg <= '0;
            end
            else if (frame_done)
            begin
                busy_reg     <= 1'b0;
                byte_idx_reg <= '0;
            end
            else if (out_take)
            begin
                byte_idx_reg <= byte_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg     <= mode_t'(s_axis_tdata[MODE_LSB +: MODE_W]);
            angle_reg    <= s_axis_tdata[ANGLE_LSB +: ANGLE_W];
            speed_reg    <= s_axis_tdata[SPEED_LSB +: SPEED_W];
            interval_reg <= s_axis_tdata[INTERVAL_LSB +: INTERVAL_W];
        end
        if (load && mode_ok)
        begin
            frame_reg[0] <= SYNC_BYTE;
            frame_reg[1] <= device_address_reg;
            frame_reg[2] <= cmd1;
            frame_reg[3] <= cmd2;
            frame_reg[4] <= data1;
            frame_reg[5] <= data2;
            frame_reg[6] <= checksum;
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = frame_reg[byte_idx_reg];
    assign m_axis_tlast  = (byte_idx_reg == LAST_IDX);

endmodule

### design/pcfe_checker.sv
`timescale 1ns / 1ps

`include "ptz_command_frame_encoder_assert.svh"

module pcfe_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pcfe_pkg::BYTE_W-1:0]        m_axis_tdata,
    input logic                               m_axis_tlast,
    input logic                               cfg_wr_en,
    input logic [pcfe_pkg::BYTE_W-1:0]        cfg_wr_data
);
    import pcfe_pkg::*;

    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  pos_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] addr_reg;
    logic              out_take;

    assign out_take = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (out_take)
        begin
            pos_next = m_axis_tlast ? '0 : pos_reg + 1'b1;
            if (pos_reg == '0)
                sum_next = '0;
            else
                sum_next = sum_reg + m_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            addr_reg <= ADDRESS_RESET;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            if (cfg_wr_en)
                addr_reg <= cfg_wr_data;
        end
    end

    `PCFE_ASSERT_IMP(a_sync_first, m_axis_tvalid && pos_reg == '0, m_axis_tdata == SYNC_BYTE)
    `PCFE_ASSERT_IMP(a_last_pos, m_axis_tvalid, m_axis_tlast == (pos_reg == LAST_IDX))
    `PCFE_ASSERT_IMP(a_address, m_axis_tvalid && pos_reg == IDX_W'(1), m_axis_tdata == addr_reg)
    `PCFE_ASSERT_IMP(a_checksum, m_axis_tvalid && m_axis_tlast, m_axis_tdata == sum_reg)
    `PCFE_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind ptz_command_frame_encoder pcfe_checker u_pcfe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
);
